### hw/rtl/qsc_pkg.sv
// ----------------------------------------------------------------------------
// qsc_pkg
// Shared types and constants of the quadrilateral shape classifier.
// ----------------------------------------------------------------------------
package qsc_pkg;

  // Shape codes on the result channel
  typedef enum logic [2:0] {
    SHAPE_SQUARE        = 3'd0,
    SHAPE_RHOMBUS       = 3'd1,
    SHAPE_RECTANGLE     = 3'd2,
    SHAPE_PARALLELOGRAM = 3'd3,
    SHAPE_TRAPEZIUM     = 3'd4,
    SHAPE_ORDINARY      = 3'd5
  } shape_code_t;

  // Edges from request accept to the edge that takes the result
  localparam int unsigned LATENCY = 7;

endpackage : qsc_pkg

### hw/rtl/qsc_sort4.sv
// ----------------------------------------------------------------------------
// qsc_sort4
// Four-input sorting network on (x, then y); the first output is the pivot.
// ----------------------------------------------------------------------------
module qsc_sort4 #(
  parameter int unsigned W = 16
) (
  input  logic signed [W-1:0] in_x  [4],
  input  logic signed [W-1:0] in_y  [4],
  output logic signed [W-1:0] out_x [4],
  output logic signed [W-1:0] out_y [4]
);

  logic signed [W-1:0] l1_x [4];
  logic signed [W-1:0] l1_y [4];
  logic signed [W-1:0] l2_x [4];
  logic signed [W-1:0] l2_y [4];

  // lexicographic (x, y) compare
  function automatic logic xy_less(input logic signed [W-1:0] ax,
                                   input logic signed [W-1:0] ay,
                                   input logic signed [W-1:0] bx,
                                   input logic signed [W-1:0] by);
    return (ax < bx) || ((ax == bx) && (ay < by));
  endfunction

  // layer 1: (0,1) (2,3)
  always_comb begin
    l1_x = in_x;
    l1_y = in_y;
    if (xy_less(in_x[1], in_y[1], in_x[0], in_y[0])) begin
      l1_x[0] = in_x[1]; l1_y[0] = in_y[1];
      l1_x[1] = in_x[0]; l1_y[1] = in_y[0];
    end
    if (xy_less(in_x[3], in_y[3], in_x[2], in_y[2])) begin
      l1_x[2] = in_x[3]; l1_y[2] = in_y[3];
      l1_x[3] = in_x[2]; l1_y[3] = in_y[2];
    end
  end

  // layer 2: (0,2) (1,3)
  always_comb begin
    l2_x = l1_x;
    l2_y = l1_y;
    if (xy_less(l1_x[2], l1_y[2], l1_x[0], l1_y[0])) begin
      l2_x[0] = l1_x[2]; l2_y[0] = l1_y[2];
      l2_x[2] = l1_x[0]; l2_y[2] = l1_y[0];
    end
    if (xy_less(l1_x[3], l1_y[3], l1_x[1], l1_y[1])) begin
      l2_x[1] = l1_x[3]; l2_y[1] = l1_y[3];
      l2_x[3] = l1_x[1]; l2_y[3] = l1_y[1];
    end
  end

  // layer 3: (1,2)
  always_comb begin
    out_x = l2_x;
    out_y = l2_y;
    if (xy_less(l2_x[2], l2_y[2], l2_x[1], l2_y[1])) begin
      out_x[1] = l2_x[2]; out_y[1] = l2_y[2];
      out_x[2] = l2_x[1]; out_y[2] = l2_y[1];
    end
  end

endmodule : qsc_sort4

### hw/rtl/quadrilateral_shape_classifier.sv
// ----------------------------------------------------------------------------
// quadrilateral_shape_classifier
// Classifies four integer points as square, rhombus, rectangle,
// parallelogram, trapezium or ordinary quadrilateral.
// ----------------------------------------------------------------------------
// Usage:
//   A request (four points on in_p*_x / in_p*_y) is taken at any rising edge
//   with start high and busy low. busy stays low: the pipeline takes a new
//   request every cycle, so throughput is one request per clock.
//   Each request produces one result: out_valid rises when its valid bit has
//   moved through v1_r to v6_r into out_valid_r, and stays high for exactly
//   one cycle with out_shape_code; the result is taken at the edge ending
//   that cycle.
//   Results come out in request order.
//   Pipeline: xy sort, pivot offsets, angle cross products, angle order,
//   edge vectors, edge products, length/parallel compares and decision.
//   The stage count, not any shared unit, sets the latency.
//   The receiver cannot stall; nothing is buffered beyond the pipeline.
//   Synchronous reset (rst_n low) clears all valid bits; requests seen
//   while in reset are dropped.
// ----------------------------------------------------------------------------
module quadrilateral_shape_classifier
  import qsc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_p0_x,
  input  logic signed [COORD_BITS-1:0] in_p0_y,
  input  logic signed [COORD_BITS-1:0] in_p1_x,
  input  logic signed [COORD_BITS-1:0] in_p1_y,
  input  logic signed [COORD_BITS-1:0] in_p2_x,
  input  logic signed [COORD_BITS-1:0] in_p2_y,
  input  logic signed [COORD_BITS-1:0] in_p3_x,
  input  logic signed [COORD_BITS-1:0] in_p3_y,
  output logic                         out_valid,
  output logic [2:0]                   out_shape_code
);

  localparam int unsigned W = COORD_BITS;
  localparam int unsigned D = W + 1;       // offset / edge width
  localparam int unsigned P = 2 * D;       // product width
  localparam int unsigned S = P + 1;       // sum of two products

  logic in_req;
  assign busy   = 1'b0;
  assign in_req = start && !busy;

  // ---------------------------------------------------------------- valids
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_req;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  // ---------------------------------------------------- stage 1: xy sort
  logic signed [W-1:0] raw_x [4];
  logic signed [W-1:0] raw_y [4];
  logic signed [W-1:0] srt_x [4];
  logic signed [W-1:0] srt_y [4];
  logic signed [W-1:0] s1_x_r [4];
  logic signed [W-1:0] s1_y_r [4];

  assign raw_x[0] = in_p0_x;
  assign raw_y[0] = in_p0_y;
  assign raw_x[1] = in_p1_x;
  assign raw_y[1] = in_p1_y;
  assign raw_x[2] = in_p2_x;
  assign raw_y[2] = in_p2_y;
  assign raw_x[3] = in_p3_x;
  assign raw_y[3] = in_p3_y;

  qsc_sort4 #(.W(W)) u_sort4 (
    .in_x  (raw_x),
    .in_y  (raw_y),
    .out_x (srt_x),
    .out_y (srt_y)
  );

  always_ff @(posedge clk) begin
    if (in_req) begin
      s1_x_r <= srt_x;
      s1_y_r <= srt_y;
    end
  end

  // ------------------------------------------- stage 2: pivot offsets
  // d: true offset; a: angle vector, a zero offset counts as direction (1,0)
  logic signed [D-1:0] d_x_nxt [3];
  logic signed [D-1:0] d_y_nxt [3];
  logic signed [D-1:0] a_x_nxt [3];
  logic signed [D-1:0] a_y_nxt [3];
  logic signed [D-1:0] s2_dx_r [3];
  logic signed [D-1:0] s2_dy_r [3];
  logic signed [D-1:0] s2_ax_r [3];
  logic signed [D-1:0] s2_ay_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_x_nxt[i] = {s1_x_r[i+1][W-1], s1_x_r[i+1]} - {s1_x_r[0][W-1], s1_x_r[0]};
      d_y_nxt[i] = {s1_y_r[i+1][W-1], s1_y_r[i+1]} - {s1_y_r[0][W-1], s1_y_r[0]};
      if ((s1_x_r[i+1] == s1_x_r[0]) && (s1_y_r[i+1] == s1_y_r[0])) begin
        a_x_nxt[i] = D'(1);
        a_y_nxt[i] = '0;
      end else begin
        a_x_nxt[i] = d_x_nxt[i];
        a_y_nxt[i] = d_y_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      s2_dx_r <= d_x_nxt;
      s2_dy_r <= d_y_nxt;
      s2_ax_r <= a_x_nxt;
      s2_ay_r <= a_y_nxt;
    end
  end

  // ------------------------------- stage 3: angle cross-product terms
  // pair k: (0,1) (0,2) (1,2); cross = m_a - m_b
  logic signed [P-1:0] s3_ma_r [3];
  logic signed [P-1:0] s3_mb_r [3];
  logic signed [D-1:0] s3_dx_r [3];
  logic signed [D-1:0] s3_dy_r [3];

  always_ff @(posedge clk) begin
    if (v2_r) begin
      s3_ma_r[0] <= s2_ax_r[0] * s2_ay_r[1];
      s3_mb_r[0] <= s2_ay_r[0] * s2_ax_r[1];
      s3_ma_r[1] <= s2_ax_r[0] * s2_ay_r[2];
      s3_mb_r[1] <= s2_ay_r[0] * s2_ax_r[2];
      s3_ma_r[2] <= s2_ax_r[1] * s2_ay_r[2];
      s3_mb_r[2] <= s2_ay_r[1] * s2_ax_r[2];
      s3_dx_r    <= s2_dx_r;
      s3_dy_r    <= s2_dy_r;
    end
  end

  // ------------------------------------------- stage 4: angle order
  // lower index goes first unless the later point has strictly less angle
  logic                s4_b01_r, s4_b02_r, s4_b12_r;
  logic signed [D-1:0] s4_dx_r [3];
  logic signed [D-1:0] s4_dy_r [3];

  always_ff @(posedge clk) begin
    if (v3_r) begin
      s4_b01_r <= (s3_ma_r[0] >= s3_mb_r[0]);
      s4_b02_r <= (s3_ma_r[1] >= s3_mb_r[1]);
      s4_b12_r <= (s3_ma_r[2] >= s3_mb_r[2]);
      s4_dx_r  <= s3_dx_r;
      s4_dy_r  <= s3_dy_r;
    end
  end

  // -------------------------------- stage 5: permute and edge vectors
  logic [1:0]          pos [3];
  logic signed [D-1:0] r_x [3];
  logic signed [D-1:0] r_y [3];
  logic signed [D-1:0] e_x_nxt [4];
  logic signed [D-1:0] e_y_nxt [4];
  logic signed [D-1:0] s5_ex_r [4];
  logic signed [D-1:0] s5_ey_r [4];

  always_comb begin
    pos[0] = {1'b0, !s4_b01_r} + {1'b0, !s4_b02_r};
    pos[1] = {1'b0,  s4_b01_r} + {1'b0, !s4_b12_r};
    pos[2] = {1'b0,  s4_b02_r} + {1'b0,  s4_b12_r};
    for (int k = 0; k < 3; k++) begin
      if (pos[0] == 2'(k)) begin
        r_x[k] = s4_dx_r[0];
        r_y[k] = s4_dy_r[0];
      end else if (pos[1] == 2'(k)) begin
        r_x[k] = s4_dx_r[1];
        r_y[k] = s4_dy_r[1];
      end else begin
        r_x[k] = s4_dx_r[2];
        r_y[k] = s4_dy_r[2];
      end
    end
    // edges of the walk q0 -> q1 -> q2 -> q3 -> q0; all fit in D bits
    e_x_nxt[0] = r_x[0];
    e_y_nxt[0] = r_y[0];
    e_x_nxt[1] = r_x[1] - r_x[0];
    e_y_nxt[1] = r_y[1] - r_y[0];
    e_x_nxt[2] = r_x[2] - r_x[1];
    e_y_nxt[2] = r_y[2] - r_y[1];
    e_x_nxt[3] = -r_x[2];
    e_y_nxt[3] = -r_y[2];
  end

  always_ff @(posedge clk) begin
    if (v4_r) begin
      s5_ex_r <= e_x_nxt;
      s5_ey_r <= e_y_nxt;
    end
  end

  // ----------------------------------------- stage 6: edge products
  logic signed [P-1:0] s6_sqx_r [4];
  logic signed [P-1:0] s6_sqy_r [4];
  logic signed [P-1:0] s6_rt_r  [2];   // dot(e3, e0) terms
  logic signed [P-1:0] s6_pa_r  [2];   // cross(e0, e2) terms
  logic signed [P-1:0] s6_pb_r  [2];   // cross(e3, e1) terms

  always_ff @(posedge clk) begin
    if (v5_r) begin
      for (int i = 0; i < 4; i++) begin
        s6_sqx_r[i] <= s5_ex_r[i] * s5_ex_r[i];
        s6_sqy_r[i] <= s5_ey_r[i] * s5_ey_r[i];
      end
      s6_rt_r[0] <= s5_ex_r[3] * s5_ex_r[0];
      s6_rt_r[1] <= s5_ey_r[3] * s5_ey_r[0];
      s6_pa_r[0] <= s5_ex_r[0] * s5_ey_r[2];
      s6_pa_r[1] <= s5_ey_r[0] * s5_ex_r[2];
      s6_pb_r[0] <= s5_ex_r[3] * s5_ey_r[1];
      s6_pb_r[1] <= s5_ey_r[3] * s5_ex_r[1];
    end
  end

  // ----------------------------- stage 7: lengths, tests and decision
  logic [S-1:0] len [4];
  logic [S-1:0] rt_sum;
  logic         right_ang, par_a, par_b;
  shape_code_t  code_nxt;
  shape_code_t  out_code_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      len[i] = {s6_sqx_r[i][P-1], s6_sqx_r[i]} + {s6_sqy_r[i][P-1], s6_sqy_r[i]};
    end
    rt_sum    = {s6_rt_r[0][P-1], s6_rt_r[0]} + {s6_rt_r[1][P-1], s6_rt_r[1]};
    right_ang = (rt_sum == '0);
    par_a     = (s6_pa_r[0] == s6_pa_r[1]);
    par_b     = (s6_pb_r[0] == s6_pb_r[1]);

    if ((len[0] == len[1]) && (len[1] == len[2]) && (len[2] == len[3])) begin
      code_nxt = right_ang ? SHAPE_SQUARE : SHAPE_RHOMBUS;
    end else if ((len[0] == len[2]) && (len[1] == len[3])) begin
      code_nxt = right_ang ? SHAPE_RECTANGLE : SHAPE_PARALLELOGRAM;
    end else if (par_a || par_b) begin
      code_nxt = SHAPE_TRAPEZIUM;
    end else begin
      code_nxt = SHAPE_ORDINARY;
    end
  end

  always_ff @(posedge clk) begin
    if (v6_r) begin
      out_code_r <= code_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_shape_code = out_code_r;

endmodule : quadrilateral_shape_classifier

### hw/rtl/qsc_checker.sv
// ----------------------------------------------------------------------------
// qsc_checker
// Port-level checks of the shape classifier, bound to the top level.
// ----------------------------------------------------------------------------
module qsc_checker
  import qsc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic signed [COORD_BITS-1:0] in_p0_x,
  input logic signed [COORD_BITS-1:0] in_p0_y,
  input logic signed [COORD_BITS-1:0] in_p1_x,
  input logic signed [COORD_BITS-1:0] in_p1_y,
  input logic signed [COORD_BITS-1:0] in_p2_x,
  input logic signed [COORD_BITS-1:0] in_p2_y,
  input logic signed [COORD_BITS-1:0] in_p3_x,
  input logic signed [COORD_BITS-1:0] in_p3_y,
  input logic                         out_valid,
  input logic [2:0]                   out_shape_code
);

  logic req;
  logic all_same;

  assign req      = start && !busy;
  assign all_same = (in_p0_x == in_p1_x) && (in_p0_x == in_p2_x) &&
                    (in_p0_x == in_p3_x) && (in_p0_y == in_p1_y) &&
                    (in_p0_y == in_p2_y) && (in_p0_y == in_p3_y);

  // every result traces back to a request a fixed latency earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(req, LATENCY))
    else $error("result without matching request");

  // every request yields a result after the fixed latency
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    req |-> ##LATENCY out_valid)
    else $error("request produced no result");

  // code stays within the defined shapes
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_shape_code <= SHAPE_ORDINARY))
    else $error("undefined shape code");

  // four coincident points classify as a square
  a_point_square: assert property (@(posedge clk) disable iff (!rst_n)
    (req && all_same) |-> ##LATENCY (out_valid && (out_shape_code == SHAPE_SQUARE)))
    else $error("coincident points not a square");

endmodule : qsc_checker

bind quadrilateral_shape_classifier qsc_checker #(
  .COORD_BITS (COORD_BITS)
) u_qsc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_p0_x        (in_p0_x),
  .in_p0_y        (in_p0_y),
  .in_p1_x        (in_p1_x),
  .in_p1_y        (in_p1_y),
  .in_p2_x        (in_p2_x),
  .in_p2_y        (in_p2_y),
  .in_p3_x        (in_p3_x),
  .in_p3_y        (in_p3_y),
  .out_valid      (out_valid),
  .out_shape_code (out_shape_code)
);

### test/tb_quadrilateral_shape_classifier.sv
// ----------------------------------------------------------------------------
// tb_quadrilateral_shape_classifier
// Self-checking bench for the quadrilateral shape classifier. Requests of four
// points go in under random idle bursts and then back to back. A monitor
// predicts the shape code of every accepted request and checks every result
// strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_quadrilateral_shape_classifier;
  import qsc_pkg::*;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned DRAIN_LIMIT = 1000;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef struct {
    longint x;
    longint y;
  } point_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  coord_t in_p0_x = '0;
  coord_t in_p0_y = '0;
  coord_t in_p1_x = '0;
  coord_t in_p1_y = '0;
  coord_t in_p2_x = '0;
  coord_t in_p2_y = '0;
  coord_t in_p3_x = '0;
  coord_t in_p3_y = '0;
  logic       out_valid;
  logic [2:0] out_shape_code;

  shape_code_t pending_shapes[$];
  int unsigned mismatch_count = 0;
  bit          idle_on = 1'b1;

  quadrilateral_shape_classifier #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_p0_x       (in_p0_x),
    .in_p0_y       (in_p0_y),
    .in_p1_x       (in_p1_x),
    .in_p1_y       (in_p1_y),
    .in_p2_x       (in_p2_x),
    .in_p2_y       (in_p2_y),
    .in_p3_x       (in_p3_x),
    .in_p3_y       (in_p3_y),
    .out_valid     (out_valid),
    .out_shape_code(out_shape_code)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic point_t offset(input point_t a, input point_t b);
    point_t r;
    r.x = b.x - a.x;
    r.y = b.y - a.y;
    return r;
  endfunction

  function automatic longint cross_z(input point_t a, input point_t b);
    return a.x * b.y - a.y * b.x;
  endfunction

  function automatic longint dot_p(input point_t a, input point_t b);
    return a.x * b.x + a.y * b.y;
  endfunction

  function automatic bit xy_before(input point_t a, input point_t b);
    if (a.x != b.x) return a.x < b.x;
    return a.y < b.y;
  endfunction

  // strictly smaller angle around the pivot; a zero offset points along +x
  function automatic bit angle_before(input point_t piv, input point_t a, input point_t b);
    point_t u;
    point_t v;
    u = offset(piv, a);
    v = offset(piv, b);
    if (u.x == 0 && u.y == 0) u.x = 1;
    if (v.x == 0 && v.y == 0) v.x = 1;
    return cross_z(u, v) > 0;
  endfunction

  function automatic shape_code_t classify_quad(input coord_t c[8]);
    point_t q[4];
    point_t t;
    longint len[4];
    bit     right;
    int     j;
    for (int i = 0; i < 4; i++) begin
      q[i].x = c[2*i];
      q[i].y = c[2*i+1];
    end
    // stable sort on (x, y): q[0] becomes the pivot
    for (int i = 1; i < 4; i++) begin
      t = q[i];
      j = i;
      while (j > 0 && xy_before(t, q[j-1])) begin
        q[j] = q[j-1];
        j--;
      end
      q[j] = t;
    end
    // stable sort of the rest by angle around the pivot
    for (int i = 2; i < 4; i++) begin
      t = q[i];
      j = i;
      while (j > 1 && angle_before(q[0], t, q[j-1])) begin
        q[j] = q[j-1];
        j--;
      end
      q[j] = t;
    end
    for (int i = 0; i < 4; i++) begin
      t = offset(q[i], q[(i+1)%4]);
      len[i] = dot_p(t, t);
    end
    right = dot_p(offset(q[0], q[3]), offset(q[0], q[1])) == 0;
    if (len[0] == len[1] && len[1] == len[2] && len[2] == len[3])
      return right ? SHAPE_SQUARE : SHAPE_RHOMBUS;
    if (len[0] == len[2] && len[1] == len[3])
      return right ? SHAPE_RECTANGLE : SHAPE_PARALLELOGRAM;
    if (cross_z(offset(q[0], q[1]), offset(q[3], q[2])) == 0 ||
        cross_z(offset(q[0], q[3]), offset(q[1], q[2])) == 0)
      return SHAPE_TRAPEZIUM;
    return SHAPE_ORDINARY;
  endfunction

  // ------------------------------------------------------ monitor and checker
  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    coord_t      seen[8];
    shape_code_t want;
    if (rst_n) begin
      // result side
      if (out_valid) begin
        if (pending_shapes.size() == 0) begin
          report_mismatch($sformatf("unexpected result shape_code=%0d", out_shape_code));
        end else begin
          want = pending_shapes.pop_front();
          if (out_shape_code !== want)
            report_mismatch($sformatf("shape_code got %0d want %0d (%s)",
                                      out_shape_code, want, want.name()));
        end
      end
      // request side
      if (start && !busy) begin
        seen = '{in_p0_x, in_p0_y, in_p1_x, in_p1_y, in_p2_x, in_p2_y, in_p3_x, in_p3_y};
        pending_shapes.push_back(classify_quad(seen));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic int rand_between(input int lo, input int hi);
    return int'($urandom_range(hi - lo)) + lo;
  endfunction

  function automatic coord_t edge_value();
    coord_t picks[7];
    picks = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7ffe, 16'sh7fff};
    return picks[$urandom_range(6)];
  endfunction

  // hands one request over and returns at the edge that takes it, or after a random idle burst if idle_on
  task automatic send_quad(input coord_t c[8]);
    start   <= 1'b1;
    in_p0_x <= c[0];
    in_p0_y <= c[1];
    in_p1_x <= c[2];
    in_p1_y <= c[3];
    in_p2_x <= c[4];
    in_p2_y <= c[5];
    in_p3_x <= c[6];
    in_p3_y <= c[7];
    do @(posedge clk); while (busy);
    if (idle_on && $urandom_range(2) == 0) begin
      start   <= 1'b0;
      in_p0_x <= coord_t'($urandom);
      in_p2_y <= coord_t'($urandom);
      repeat ($urandom_range(13, 1)) @(posedge clk);
    end
  endtask

  // quadrilateral built for a chosen kind (random corners for ordinary), corners in random order
  function automatic void build_shape(input shape_code_t kind, output coord_t c[8]);
    int px[4];
    int py[4];
    int r, a, b, dx, dy, ox, oy, m, n, k, tmp;
    case ($urandom_range(2))
      0: r = 3;
      1: r = 60;
      default: r = 4000;
    endcase
    ox = rand_between(-16000, 16000);
    oy = rand_between(-16000, 16000);
    a  = rand_between(-r, r);
    b  = rand_between(-r, r);
    dx = rand_between(-r, r);
    dy = rand_between(-r, r);
    m  = rand_between(1, 3);
    n  = rand_between(1, 3);
    k  = rand_between(2, 3);
    case (kind)
      SHAPE_SQUARE: begin
        dx = -b;
        dy = a;
      end
      SHAPE_RHOMBUS: begin
        dx = ($urandom_range(1)) ? b : -b;
        dy = a;
        tmp = dx; dx = dy; dy = tmp;
      end
      SHAPE_RECTANGLE: begin
        dx = -k * b;
        dy = k * a;
      end
      default: ;
    endcase
    px[0] = ox;
    py[0] = oy;
    if (kind == SHAPE_TRAPEZIUM) begin
      px[1] = ox + m * a;      py[1] = oy + m * b;
      px[2] = ox + dx + n * a; py[2] = oy + dy + n * b;
    end else begin
      px[1] = ox + a;          py[1] = oy + b;
      px[2] = ox + a + dx;     py[2] = oy + b + dy;
    end
    px[3] = ox + dx;
    py[3] = oy + dy;
    if (kind == SHAPE_ORDINARY) begin
      for (int i = 1; i < 4; i++) begin
        px[i] = ox + rand_between(-3 * r, 3 * r);
        py[i] = oy + rand_between(-3 * r, 3 * r);
      end
    end
    // shuffle the corners
    for (int i = 3; i > 0; i--) begin
      k = $urandom_range(i);
      tmp = px[i]; px[i] = px[k]; px[k] = tmp;
      tmp = py[i]; py[i] = py[k]; py[k] = tmp;
    end
    for (int i = 0; i < 4; i++) begin
      c[2*i]   = coord_t'(px[i]);
      c[2*i+1] = coord_t'(py[i]);
    end
  endfunction

  // arbitrary points: full range, tiny grid (repeats, collinear) or extremes mixed with random values
  function automatic void build_noise(output coord_t c[8]);
    int mode;
    mode = $urandom_range(2);
    for (int i = 0; i < 8; i++) begin
      case (mode)
        0: c[i] = coord_t'($urandom);
        1: c[i] = coord_t'(rand_between(-3, 3));
        default: c[i] = ($urandom_range(1)) ? edge_value() : coord_t'($urandom);
      endcase
    end
  endfunction

  task automatic test_directed();
    coord_t quads[][8];
    quads = '{
      // four equal points
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
        16'sh8000, 16'sh8000},
      '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
        16'sh7fff, 16'sh7fff},
      // full-range square, scrambled corners
      '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff,
        16'sh7fff, 16'sh8000},
      // full-range diamond
      '{16'sh8001, 16'sd0, 16'sd0, 16'sh8001, 16'sh7fff, 16'sd0, 16'sd0, 16'sh7fff},
      '{16'sh8000, 16'sd0, 16'sd0, 16'sh8000, 16'sh7fff, 16'sd0, 16'sd0, 16'sh7fff},
      // one of each shape
      '{16'sd0, 16'sd0, 16'sd5, 16'sd0, 16'sd8, 16'sd4, 16'sd3, 16'sd4},
      '{16'sd4, 16'sd2, 16'sd0, 16'sd0, 16'sd4, 16'sd0, 16'sd0, 16'sd2},
      '{16'sd0, 16'sd0, 16'sd4, 16'sd0, 16'sd5, 16'sd2, 16'sd1, 16'sd2},
      '{16'sd0, 16'sd0, 16'sd6, 16'sd0, 16'sd4, 16'sd2, 16'sd1, 16'sd2},
      '{16'sd0, 16'sd0, 16'sd5, 16'sd1, 16'sd7, 16'sd6, -16'sd1, 16'sd4},
      '{16'sd10, 16'sd10, 16'sd12, 16'sd11, 16'sd11, 16'sd13, 16'sd9, 16'sd12},
      // ties on x broken by y, among the other points and at the pivot
      '{16'sd0, 16'sd3, 16'sd0, -16'sd3, 16'sd2, 16'sd0, -16'sd2, 16'sd0},
      '{16'sd0, 16'sd5, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd3, 16'sd5},
      // a point on top of the pivot
      '{16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd4, 16'sd1, 16'sd4, 16'sd5},
      '{16'sd2, 16'sd2, 16'sd5, -16'sd3, 16'sd2, 16'sd2, 16'sd5, 16'sd7},
      // equal angles around the pivot
      '{16'sd2, 16'sd2, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd3, 16'sd0},
      '{16'sd3, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd2, 16'sd4},
      // vertical offsets from the pivot
      '{16'sd0, 16'sd0, 16'sd0, 16'sd7, 16'sd0, 16'sd3, 16'sd2, 16'sd1},
      // all collinear, and two repeated pairs
      '{16'sd0, 16'sd0, 16'sd1, 16'sd2, 16'sd2, 16'sd4, 16'sd3, 16'sd6},
      '{16'sd5, 16'sd5, 16'sh8000, 16'sh7fff, 16'sd5, 16'sd5, 16'sh8000, 16'sh7fff},
      // mixed extremes
      '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, -16'sd1, 16'sd0, 16'sd1, -16'sd1},
      '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
        16'sh8000, 16'sh7ffe}
    };
    foreach (quads[i]) send_quad(quads[i]);
  endtask

  task automatic test_random_shapes(input int count);
    coord_t c[8];
    for (int i = 0; i < count; i++) begin
      build_shape(shape_code_t'($urandom_range(5)), c);
      send_quad(c);
    end
  endtask

  task automatic test_random_noise(input int count);
    coord_t c[8];
    for (int i = 0; i < count; i++) begin
      build_noise(c);
      send_quad(c);
    end
  endtask

  task automatic test_back_to_back(input int count);
    coord_t c[8];
    idle_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) build_noise(c);
      else build_shape(shape_code_t'($urandom_range(5)), c);
      send_quad(c);
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    int unsigned waited;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_shapes(1000);
    test_random_noise(500);
    test_back_to_back(250);
    start <= 1'b0;

    // drain the pipeline
    waited = 0;
    while (pending_shapes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_shapes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_shapes.size()));
    repeat (LATENCY + 4) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
hw/rtl/qsc_pkg.sv
hw/rtl/qsc_sort4.sv
hw/rtl/quadrilateral_shape_classifier.sv
hw/rtl/qsc_checker.sv
test/tb_quadrilateral_shape_classifier.sv
